/* hw/rtl/b64d_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and helper functions of the Base64 stream decoder.
// ----------------------------------------------------------------------------

package b64d_pkg;

  // How a text ended, reported on its final result
  typedef enum logic [1:0] {
    END_RAN_OUT = 2'd0,
    END_PAD     = 2'd1,
    END_BAD     = 2'd2
  } end_status_t;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  localparam int JOB_FIFO_DEPTH = 4;
  localparam int JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);
  localparam int JOB_CNT_W      = $clog2(JOB_FIFO_DEPTH + 1);

  // Work handed from the front end to the back end for one character
  typedef struct packed {
    logic [2:0][7:0] data;    // decoded bytes, entry 0 goes out first
    logic [1:0]      nbytes;  // bytes to send, 0 for a pure end marker
    logic            last;    // character closed the text
    end_status_t     status;  // how the text ended, meaningful with last
  } job_t;

  // Sextet value of an alphabet character; bit 6 set for anything else
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      return {1'b0, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      return {1'b0, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      return {1'b0, t[5:0]};
    end else if (c == 8'h2B) begin
      return 7'd62;
    end else if (c == 8'h2F) begin
      return 7'd63;
    end
    return 7'h40;
  endfunction

  // Pack four sextets into three bytes
  function automatic logic [2:0][7:0] group_bytes(input logic [5:0] s0,
                                                  input logic [5:0] s1,
                                                  input logic [5:0] s2,
                                                  input logic [5:0] s3);
    logic [2:0][7:0] b;
    b[0] = {s0, s1[5:4]};
    b[1] = {s1[3:0], s2[5:2]};
    b[2] = {s2[1:0], s3};
    return b;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/b64d_char_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_char_if
// Character channel: one ASCII character and its end-of-text flag.
// ----------------------------------------------------------------------------

interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

`default_nettype wire

/* hw/rtl/b64d_res_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_res_if
// Result channel: one decoded byte or end marker per transfer.
// ----------------------------------------------------------------------------

interface b64d_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  logic [1:0] end_status;

  modport source (output valid, data_byte, byte_valid, last, end_status, input ready);
  modport sink   (input valid, data_byte, byte_valid, last, end_status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/b64d_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks prefix skip, sextet grouping and halt state,
// and turns each character that yields bytes or ends a text into one job.
// ----------------------------------------------------------------------------

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  b64d_char_if.sink       chars,
  input  wire logic       job_full,
  output logic            job_push,
  output job_t            job
);

  logic [7:0]  skip_count;
  logic [7:0]  skip_left;
  logic [5:0]  h0, h1, h2;
  logic [1:0]  cnt;
  logic        halted;
  end_status_t reason;
  logic        mid_text;

  logic        accept;
  logic [6:0]  sx;
  logic [5:0]  h0_next, h1_next, h2_next;
  logic [1:0]  cnt_upd;
  logic        halted_upd;
  end_status_t reason_upd;
  logic [7:0]  skip_next;
  logic        full_emit;
  logic        flush;

  assign chars.ready = !job_full;
  assign accept      = chars.valid && chars.ready;
  assign sx          = sextet_of(chars.char_code);

  always_comb begin
    h0_next    = h0;
    h1_next    = h1;
    h2_next    = h2;
    cnt_upd    = cnt;
    halted_upd = halted;
    reason_upd = reason;
    skip_next  = skip_left;
    full_emit  = 1'b0;
    flush      = 1'b0;

    if (skip_left != 8'd0) begin
      skip_next = skip_left - 8'd1;
    end else if (!halted) begin
      if (!sx[6]) begin
        if (cnt == 2'd3) begin
          full_emit = 1'b1;
        end else begin
          case (cnt)
            2'd0:    h0_next = sx[5:0];
            2'd1:    h1_next = sx[5:0];
            default: h2_next = sx[5:0];
          endcase
          cnt_upd = cnt + 2'd1;
        end
      end else begin
        halted_upd = 1'b1;
        reason_upd = (chars.char_code == CHAR_PAD) ? END_PAD : END_BAD;
        flush      = 1'b1;
      end
    end

    // end of text flushes a partial group unless a halt already did
    if (chars.end_of_text && !halted_upd) begin
      flush = 1'b1;
    end

    if (full_emit) begin
      job.data   = group_bytes(h0, h1, h2, sx[5:0]);
      job.nbytes = 2'd3;
    end else begin
      job.data   = group_bytes(h0_next, h1_next, h2_next, 6'd0);
      job.nbytes = (flush && cnt_upd > 2'd1) ? cnt_upd - 2'd1 : 2'd0;
    end
    job.last   = chars.end_of_text;
    job.status = halted_upd ? reason_upd : END_RAN_OUT;

    job_push = accept && (job.nbytes != 2'd0 || chars.end_of_text);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count <= 8'd0;
      skip_left  <= 8'd0;
      cnt        <= 2'd0;
      halted     <= 1'b0;
      reason     <= END_RAN_OUT;
      mid_text   <= 1'b0;
    end else begin
      if (accept) begin
        h0 <= h0_next;
        h1 <= h1_next;
        h2 <= h2_next;
        if (chars.end_of_text) begin
          cnt       <= 2'd0;
          halted    <= 1'b0;
          reason    <= END_RAN_OUT;
          skip_left <= skip_count;
          mid_text  <= 1'b0;
        end else begin
          cnt       <= (full_emit || flush) ? 2'd0 : cnt_upd;
          halted    <= halted_upd;
          reason    <= reason_upd;
          skip_left <= skip_next;
          mid_text  <= 1'b1;
        end
      end
      if (cfg_we) begin
        skip_count <= cfg_wdata;
        if (!mid_text) begin
          skip_left <= cfg_wdata;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/b64d_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_fifo
// Short job queue between front and back end.
// ----------------------------------------------------------------------------

module b64d_fifo
  import b64d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      empty
);

  job_t                 mem [JOB_FIFO_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr;
  logic [JOB_PTR_W-1:0] rd_ptr;
  logic [JOB_CNT_W-1:0] count;

  assign full     = (count == JOB_CNT_W'(JOB_FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/b64d_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_back
// Walks the head job byte by byte into the registered result channel.
// ----------------------------------------------------------------------------

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t head,
  input  wire logic empty,
  output logic      pop,
  b64d_res_if.source results
);

  logic [1:0]  idx;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last;
  end_status_t out_status;

  logic        load;
  logic        final_byte;

  assign load       = !empty && (!out_valid || results.ready);
  assign final_byte = (head.nbytes == 2'd0) || (idx == head.nbytes - 2'd1);
  assign pop        = load && final_byte;

  assign results.valid      = out_valid;
  assign results.data_byte  = out_byte;
  assign results.byte_valid = out_byte_valid;
  assign results.last       = out_last;
  assign results.end_status = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= final_byte ? 2'd0 : idx + 2'd1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_valid <= (head.nbytes != 2'd0);
      out_byte       <= (head.nbytes != 2'd0) ? head.data[idx] : 8'd0;
      out_last       <= head.last && final_byte;
      out_status     <= (head.last && final_byte) ? head.status : END_RAN_OUT;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/base64_stream_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 decoder, one character in per transfer.
// ----------------------------------------------------------------------------
// Use: characters arrive on the chars channel with end_of_text on the final
// character of each text. The first skip_count characters of a text are
// dropped; skip_count is written through cfg_we/cfg_wdata while idle.
// Decoded bytes leave on the results channel, one per transfer; the final
// transfer of a text carries last and end_status (a pure marker with
// byte_valid low when the text yields no byte on its final character).
// Timing: a character is taken every cycle while the job queue has room.
// Its first result passes through the job queue and then the result register.
// It sends one byte a cycle while the receiver is ready, so a character
// completing a group occupies the back end for one transfer per byte; the
// four-entry job queue absorbs this, and the average of three bytes per four
// characters keeps the input at one character per cycle while the receiver is ready.
// Reset: clears skip_count, the group state, the halt flag and the queue.
// Receiver stall: the result register holds, the queue fills, then chars
// ready drops until the back end drains an entry.
// ----------------------------------------------------------------------------

module base64_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  b64d_char_if.sink       chars,
  b64d_res_if.source      results
);

  // front end to queue
  job_t job_in;
  logic job_push;
  logic job_full;

  // queue to back end
  job_t job_head;
  logic job_pop;
  logic job_empty;

  // Classify each character and build its job
  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .chars     (chars),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (job_in)
  );

  // Decouple character intake from byte output
  b64d_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_head),
    .empty     (job_empty)
  );

  // Serialise each job into result transfers
  b64d_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (job_head),
    .empty   (job_empty),
    .pop     (job_pop),
    .results (results)
  );

endmodule

`default_nettype wire
